/* hw/rtl/matrix4x4_multiply_top_defines.svh */
// Assertion macros used by the matrix multiply top level.
`ifndef MATRIX4X4_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/mm4_pkg.sv */
// Package with the fixed field widths and the token tag of the matrix multiply chain.
`default_nettype none
package mm4_pkg;

   // Fixed widths of the transaction fields.
   localparam int IDX_W  = 4;
   localparam int VAL_W  = 32;
   localparam int PROD_W = 2 * VAL_W;

   // Control part of a token that travels down the cell chain.
   typedef struct packed {
      logic valid;
      logic last;
   } mm4_tag_type;

endpackage
`default_nettype wire

/* hw/rtl/matrix4x4_multiply_top.sv */
// Top level of the fixed-point matrix multiplier: load decode, issue sequencer, cell chain.
//
//  Channel | Ports  | Carries
//  --------+--------+---------------------------------------------------------
//  input   | req_*  | elem_index, left_value, right_value (one element pair)
//  result  | rsp_*  | out_index, product_value, saturated, last_result
//
// The transaction at the last index stores its elements and then issues DIM*DIM dot
// products, one per cycle while no result stalls, into a chain of DIM cells; each cell
// registers one product and then adds it to the partial sum, and the last cell feeds
// the output register.
// Reset clears the sequencer and the valid bits; the element stores are not cleared.
// A stalled result freezes the whole chain; loads are refused until the last result
// has left the chain.
`default_nettype none
`include "matrix4x4_multiply_top_defines.svh"
module matrix4x4_multiply_top
   import mm4_pkg::*;
#(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [IDX_W-1:0]        req_elem_index,
   input  logic signed [VAL_W-1:0] req_left_value,
   input  logic signed [VAL_W-1:0] req_right_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_out_index,
   output logic signed [VAL_W-1:0] rsp_product_value,
   output logic                    rsp_saturated,
   output logic                    rsp_last_result
);

   localparam int RW    = $clog2(DIM);
   localparam int SW    = PROD_W + $clog2(DIM);
   localparam int CELLS = DIM * DIM;
   localparam logic [RW-1:0] LAST_RC = RW'(DIM - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type     state_ff;
   logic [RW-1:0] row_ff, col_ff;

   logic          adv;
   logic          load_fire, in_range, is_last_idx, wr_en, drain_done;
   logic [RW-1:0] wr_row, wr_col;

   mm4_tag_type          tag_c [DIM+1];
   logic [RW-1:0]        row_c [DIM+1];
   logic [RW-1:0]        col_c [DIM+1];
   logic signed [SW-1:0] acc_c [DIM+1];

   // Load decode: split the row-major index into row and column.
   always_comb begin
      wr_row = '0;
      for (int r = 0; r < DIM; r++) begin
         if (32'(req_elem_index) >= r * DIM) begin
            wr_row = RW'(r);
         end
      end
      wr_col = RW'(32'(req_elem_index) - 32'(wr_row) * DIM);
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign load_fire   = req_valid && req_ready;
   assign in_range    = 32'(req_elem_index) < CELLS;
   assign is_last_idx = 32'(req_elem_index) == CELLS - 1;
   assign wr_en       = load_fire && in_range;
   assign drain_done  = tag_c[DIM].valid && tag_c[DIM].last && adv;

   // Issue sequencer: walks row and column over the product elements.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (load_fire && is_last_idx) begin
                  state_ff <= ST_ISSUE;
                  row_ff   <= '0;
                  col_ff   <= '0;
               end
            end
            ST_ISSUE: begin
               if (adv) begin
                  if (col_ff == LAST_RC) begin
                     col_ff <= '0;
                     if (row_ff == LAST_RC) begin
                        state_ff <= ST_DRAIN;
                     end else begin
                        row_ff <= row_ff + RW'(1);
                     end
                  end else begin
                     col_ff <= col_ff + RW'(1);
                  end
               end
            end
            ST_DRAIN: begin
               if (drain_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Head of the chain: a new token each cycle while issuing and not stalled, with a zero sum.
   assign tag_c[0].valid = (state_ff == ST_ISSUE);
   assign tag_c[0].last  = (row_ff == LAST_RC) && (col_ff == LAST_RC);
   assign row_c[0]       = row_ff;
   assign col_c[0]       = col_ff;
   assign acc_c[0]       = '0;

   // Chain of multiply-accumulate cells, cell k adds left[row][k] * right[k][col].
   for (genvar k = 0; k < DIM; k++) begin : g_cell
      mm4_cell #(
         .DIM (DIM),
         .K   (k),
         .RW  (RW),
         .SW  (SW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .wr_en    (wr_en),
         .wr_row   (wr_row),
         .wr_col   (wr_col),
         .wr_left  (req_left_value),
         .wr_right (req_right_value),
         .tag_up   (tag_c[k]),
         .row_up   (row_c[k]),
         .col_up   (col_c[k]),
         .acc_up   (acc_c[k]),
         .tag_dn   (tag_c[k+1]),
         .row_dn   (row_c[k+1]),
         .col_dn   (col_c[k+1]),
         .acc_dn   (acc_c[k+1])
      );
   end

   // Scaling, saturation and the result register.
   mm4_out #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS),
      .RW        (RW),
      .SW        (SW)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .tag               (tag_c[DIM]),
      .row               (row_c[DIM]),
      .col               (col_c[DIM]),
      .acc               (acc_c[DIM]),
      .adv               (adv),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_index     (rsp_out_index),
      .rsp_product_value (rsp_product_value),
      .rsp_saturated     (rsp_saturated),
      .rsp_last_result   (rsp_last_result)
   );

   // The transaction at the last index starts issuing in the next cycle.
   `MM4_ASSERT_NEXT(a_start_issue, load_fire && is_last_idx, state_ff == ST_ISSUE,
      "last index did not start the product")
   // When the final token leaves the chain, its result is shown and loads reopen.
   `MM4_ASSERT_NEXT(a_drain_end, drain_done, rsp_valid && rsp_last_result &&
      state_ff == ST_IDLE, "final result not delivered at end of drain")
   // A stalled chain must not lose issue positions.
   `MM4_ASSERT_NEXT(a_issue_hold, state_ff == ST_ISSUE && !adv,
      $stable(row_ff) && $stable(col_ff), "issue position moved during a stall")

endmodule
`default_nettype wire

/* hw/rtl/mm4_cell.sv */
// One multiply-accumulate cell of the chain, with a left column and a right row.
`default_nettype none
module mm4_cell
   import mm4_pkg::*;
#(
   parameter int DIM = 4,
   parameter int K   = 0,
   parameter int RW  = 2,
   parameter int SW  = 66
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    wr_en,
   input  logic [RW-1:0]           wr_row,
   input  logic [RW-1:0]           wr_col,
   input  logic signed [VAL_W-1:0] wr_left,
   input  logic signed [VAL_W-1:0] wr_right,
   input  mm4_tag_type             tag_up,
   input  logic [RW-1:0]           row_up,
   input  logic [RW-1:0]           col_up,
   input  logic signed [SW-1:0]    acc_up,
   output mm4_tag_type             tag_dn,
   output logic [RW-1:0]           row_dn,
   output logic [RW-1:0]           col_dn,
   output logic signed [SW-1:0]    acc_dn
);

   // Element k of every left row and every right column; written only when idle.
   logic signed [VAL_W-1:0] left_col_ff  [DIM];
   logic signed [VAL_W-1:0] right_row_ff [DIM];

   mm4_tag_type              tag1_ff, tag2_ff;
   logic [RW-1:0]            row1_ff, col1_ff, row2_ff, col2_ff;
   logic signed [SW-1:0]     acc1_ff, acc2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SW-1:0]     acc2_in;

   // Store the loaded elements that belong to this cell.
   always_ff @(posedge clock) begin
      if (wr_en && wr_col == RW'(K)) begin
         left_col_ff[wr_row] <= wr_left;
      end
      if (wr_en && wr_row == RW'(K)) begin
         right_row_ff[wr_col] <= wr_right;
      end
   end

   // Exact product of left[row][k] and right[k][col].
   assign prod_in = PROD_W'(left_col_ff[row_up]) * PROD_W'(right_row_ff[col_up]);

   // Add the registered product to the partial sum coming from the previous cell.
   assign acc2_in = acc1_ff + SW'(prod_ff);

   // Tag registers of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (adv) begin
         tag1_ff <= tag_up;
         tag2_ff <= tag1_ff;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         row1_ff <= row_up;
         col1_ff <= col_up;
         acc1_ff <= acc_up;
         row2_ff <= row1_ff;
         col2_ff <= col1_ff;
         acc2_ff <= acc2_in;
      end
   end

   assign tag_dn = tag2_ff;
   assign row_dn = row2_ff;
   assign col_dn = col2_ff;
   assign acc_dn = acc2_ff;

endmodule
`default_nettype wire

/* hw/rtl/mm4_out.sv */
// Final stage: drops the fraction bits, saturates, and holds the result transaction.
`default_nettype none
module mm4_out
   import mm4_pkg::*;
#(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16,
   parameter int RW        = 2,
   parameter int SW        = 66
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mm4_tag_type             tag,
   input  logic [RW-1:0]           row,
   input  logic [RW-1:0]           col,
   input  logic signed [SW-1:0]    acc,
   output logic                    adv,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_out_index,
   output logic signed [VAL_W-1:0] rsp_product_value,
   output logic                    rsp_saturated,
   output logic                    rsp_last_result
);

   localparam logic signed [SW-1:0] MAX_V = SW'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [SW-1:0] MIN_V = SW'(64'shFFFF_FFFF_8000_0000);

   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        index_ff, index_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic                    sat_ff, sat_in;
   logic                    last_ff;
   logic signed [SW-1:0]    shifted;

   // The whole chain moves unless a result waits that is not taken.
   assign adv = !rsp_valid_ff || rsp_ready;

   // Truncate toward minus infinity, then clip to the 32-bit range.
   always_comb begin
      shifted = acc >>> FRAC_BITS;
      if (shifted > MAX_V) begin
         value_in = 32'sh7FFF_FFFF;
         sat_in   = 1'b1;
      end else if (shifted < MIN_V) begin
         value_in = 32'sh8000_0000;
         sat_in   = 1'b1;
      end else begin
         value_in = shifted[VAL_W-1:0];
         sat_in   = 1'b0;
      end
      index_in = IDX_W'(32'(row) * DIM + 32'(col));
   end

   // Output valid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tag.valid;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      if (adv && tag.valid) begin
         index_ff <= index_in;
         value_ff <= value_in;
         sat_ff   <= sat_in;
         last_ff  <= tag.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_index     = index_ff;
   assign rsp_product_value = value_ff;
   assign rsp_saturated     = sat_ff;
   assign rsp_last_result   = last_ff;

endmodule
`default_nettype wire
